/* rtl/tvu_pkg.sv */
// ----------------------------------------------------------------------------
// tvu_pkg
// shared constants for the tetrahedron volume unit
// ----------------------------------------------------------------------------
`default_nettype none
package tvu_pkg;
   // width of the volume result field
   localparam int unsigned VOLUME_W     = 32;
   // bits of the scaled magnitude kept before saturation
   localparam int unsigned QUOT_IN_BITS = 35;
   // divide by three: stages and bits per stage (stages * bits = QUOT_IN_BITS)
   localparam int unsigned DIV_STAGES   = 5;
   localparam int unsigned DIV_BITS     = 7;
   localparam logic [2:0]  DIVISOR      = 3'd3;
   // rounding bias before divide by six
   localparam logic [2:0]  ROUND_BIAS   = 3'd3;
endpackage
`default_nettype wire

/* rtl/tetrahedron_volume_unit.sv */
// ----------------------------------------------------------------------------
// tetrahedron_volume_unit
// volume of a tetrahedron from four fixed-point vertices
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | four vertices, x y z each
//  rsp_    | out       | rsp_valid/rsp_stall | volume, degenerate
//
// one item per cycle sustained while rsp_stall is low; rsp_valid rises once
// the accepted item has passed the queue write, four determinant and scaling
// stages, five divide-by-three stages and the result register
// throughput is set by the back pipeline, which advances whenever the result
// register is empty or taken; a stalled result freezes all of it
// the front keeps accepting until the queue fills, then raises req_stall
// synchronous reset clears the queue and every stage valid
`default_nettype none
module tetrahedron_volume_unit #(
   parameter int unsigned COORD_FRAC_BITS  = 16,
   parameter int unsigned VOLUME_FRAC_BITS = 32,
   parameter int unsigned QUEUE_DEPTH      = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_a_x,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_a_y,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_a_z,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_b_x,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_b_y,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_b_z,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_c_x,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_c_y,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_c_z,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_d_x,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_d_y,
   input  wire logic [COORD_FRAC_BITS:0]      req_vertex_d_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tvu_pkg::VOLUME_W-1:0]       rsp_volume,
   output logic                               rsp_degenerate
);
   // classified item: degenerate flag plus nine signed edge components
   localparam int unsigned IW = 9 * (COORD_FRAC_BITS + 2) + 1;

   logic [IW-1:0] front_item;
   logic [IW-1:0] head_item;
   logic          queue_full;
   logic          head_valid;
   logic          back_pop;

   // front: edges relative to vertex a and the coincident-d check
   tvu_front #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .a_x  (req_vertex_a_x),
      .a_y  (req_vertex_a_y),
      .a_z  (req_vertex_a_z),
      .b_x  (req_vertex_b_x),
      .b_y  (req_vertex_b_y),
      .b_z  (req_vertex_b_z),
      .c_x  (req_vertex_c_x),
      .c_y  (req_vertex_c_y),
      .c_z  (req_vertex_c_z),
      .d_x  (req_vertex_d_x),
      .d_y  (req_vertex_d_y),
      .d_z  (req_vertex_d_z),
      .item (front_item)
   );

   // queue decouples acceptance from the arithmetic pipeline
   tvu_queue #(
      .WIDTH (IW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_data  (front_item),
      .full       (queue_full),
      .pop        (back_pop),
      .head_valid (head_valid),
      .head_data  (head_item)
   );

   assign req_stall = queue_full;

   // back: determinant, scaling with rounding, divide by six, saturation
   tvu_back #(
      .COORD_FRAC_BITS  (COORD_FRAC_BITS),
      .VOLUME_FRAC_BITS (VOLUME_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_item),
      .pop            (back_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_volume     (rsp_volume),
      .rsp_degenerate (rsp_degenerate)
   );

`ifndef SYNTHESIS
   // a degenerate item always reports zero volume
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_volume == '0)
      else $error("degenerate item with nonzero volume");

   // nothing leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an item pushed into the empty pipeline right after reset cannot show up on the next edge
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |=> !rsp_valid)
      else $error("result valid too soon after reset");
`endif
endmodule
`default_nettype wire

/* rtl/tvu_front.sv */
// ----------------------------------------------------------------------------
// tvu_front
// forms edge vectors relative to vertex a and flags degenerate items
// ----------------------------------------------------------------------------
`default_nettype none
module tvu_front #(
   parameter int unsigned COORD_FRAC_BITS = 16
) (
   input  wire logic [COORD_FRAC_BITS:0]         a_x,
   input  wire logic [COORD_FRAC_BITS:0]         a_y,
   input  wire logic [COORD_FRAC_BITS:0]         a_z,
   input  wire logic [COORD_FRAC_BITS:0]         b_x,
   input  wire logic [COORD_FRAC_BITS:0]         b_y,
   input  wire logic [COORD_FRAC_BITS:0]         b_z,
   input  wire logic [COORD_FRAC_BITS:0]         c_x,
   input  wire logic [COORD_FRAC_BITS:0]         c_y,
   input  wire logic [COORD_FRAC_BITS:0]         c_z,
   input  wire logic [COORD_FRAC_BITS:0]         d_x,
   input  wire logic [COORD_FRAC_BITS:0]         d_y,
   input  wire logic [COORD_FRAC_BITS:0]         d_z,
   output logic [9*(COORD_FRAC_BITS+2):0]        item
);
   localparam int unsigned EW = COORD_FRAC_BITS + 2;

   logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z;
   logic                 degen;

   assign e1x = $signed({1'b0, b_x}) - $signed({1'b0, a_x});
   assign e1y = $signed({1'b0, b_y}) - $signed({1'b0, a_y});
   assign e1z = $signed({1'b0, b_z}) - $signed({1'b0, a_z});
   assign e2x = $signed({1'b0, c_x}) - $signed({1'b0, a_x});
   assign e2y = $signed({1'b0, c_y}) - $signed({1'b0, a_y});
   assign e2z = $signed({1'b0, c_z}) - $signed({1'b0, a_z});
   assign e3x = $signed({1'b0, d_x}) - $signed({1'b0, a_x});
   assign e3y = $signed({1'b0, d_y}) - $signed({1'b0, a_y});
   assign e3z = $signed({1'b0, d_z}) - $signed({1'b0, a_z});

   // d on top of any other vertex zeroes the opposite-edge product
   assign degen = (d_x == a_x && d_y == a_y && d_z == a_z) ||
                  (d_x == b_x && d_y == b_y && d_z == b_z) ||
                  (d_x == c_x && d_y == c_y && d_z == c_z);

   assign item = {degen, e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z};
endmodule
`default_nettype wire

/* rtl/tvu_queue.sv */
// ----------------------------------------------------------------------------
// tvu_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module tvu_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);
   localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNTW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

/* rtl/tvu_back.sv */
// ----------------------------------------------------------------------------
// tvu_back
// determinant pipeline, scaling, divide by six and result register
// ----------------------------------------------------------------------------
`default_nettype none
module tvu_back #(
   parameter int unsigned COORD_FRAC_BITS  = 16,
   parameter int unsigned VOLUME_FRAC_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             head_valid,
   input  wire logic [9*(COORD_FRAC_BITS+2):0]   head_data,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [tvu_pkg::VOLUME_W-1:0]          rsp_volume,
   output logic                                  rsp_degenerate
);
   localparam int unsigned EW    = COORD_FRAC_BITS + 2;
   localparam int unsigned PW    = 2 * EW;
   localparam int unsigned CW    = PW + 1;
   localparam int unsigned TW    = EW + CW;
   localparam int unsigned DW    = TW + 2;
   localparam int unsigned XW    = DW + VOLUME_FRAC_BITS;
   localparam int unsigned SCALE = 3 * COORD_FRAC_BITS;
   localparam int unsigned QW    = tvu_pkg::QUOT_IN_BITS;
   localparam int unsigned DS    = tvu_pkg::DIV_STAGES;
   localparam int unsigned DB    = tvu_pkg::DIV_BITS;
   localparam int unsigned VW    = tvu_pkg::VOLUME_W;

   function automatic logic [DB+1:0] div_chunk(input logic [1:0] r_i,
                                               input logic [DB-1:0] b_i);
      logic [2:0]    t;
      logic [1:0]    r;
      logic [DB-1:0] q;
      r = r_i;
      q = '0;
      for (int i = DB - 1; i >= 0; i--) begin
         t = {r, b_i[i]};
         if (t >= tvu_pkg::DIVISOR) begin
            q[i] = 1'b1;
            t    = t - tvu_pkg::DIVISOR;
         end
         r = t[1:0];
      end
      return {r, q};
   endfunction

   logic adv;
   logic signed [EW-1:0] e_w [9];

   // stage 1: cofactor products
   logic                 s1_v_ff, s1_dg_ff;
   logic signed [EW-1:0] s1_e_ff [3];
   logic signed [PW-1:0] s1_p_ff [6], s1_p_in [6];
   // stage 2: cofactors times first edge
   logic                 s2_v_ff, s2_dg_ff;
   logic signed [CW-1:0] c_w [3];
   logic signed [TW-1:0] s2_t_ff [3], s2_t_in [3];
   // stage 3: determinant magnitude
   logic                 s3_v_ff, s3_dg_ff;
   logic signed [DW-1:0] det_w;
   logic [DW-1:0]        s3_mag_ff, s3_mag_in;
   // stage 4: scale, saturate, round bias, halve
   logic                 s4_v_ff, s4_dg_ff, s4_sat_ff, s4_sat_in;
   logic [XW-1:0]        sh_w;
   logic [QW:0]          biased_w;
   logic [QW-1:0]        s4_m_ff;
   // divide by three stages
   logic                 dv_ff [DS];
   logic                 ddg_ff [DS];
   logic                 dsat_ff [DS];
   logic [1:0]           dr_ff [DS];
   logic [QW-1:0]        dw_ff [DS];
   logic [1:0]           dr_in [DS];
   logic [QW-1:0]        dw_in [DS];
   // result register
   logic                 rsp_valid_ff;
   logic [VW-1:0]        rsp_volume_ff, vol_in;
   logic                 rsp_degenerate_ff;
   logic [QW-1:0]        q_w;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   for (genvar k = 0; k < 9; k++) begin : g_unpack
      assign e_w[k] = $signed(head_data[(8-k)*EW +: EW]);
   end

   always_comb begin
      s1_p_in[0] = e_w[4] * e_w[8];
      s1_p_in[1] = e_w[5] * e_w[7];
      s1_p_in[2] = e_w[3] * e_w[8];
      s1_p_in[3] = e_w[5] * e_w[6];
      s1_p_in[4] = e_w[3] * e_w[7];
      s1_p_in[5] = e_w[4] * e_w[6];
   end

   always_comb begin
      c_w[0]     = CW'(s1_p_ff[0]) - CW'(s1_p_ff[1]);
      c_w[1]     = CW'(s1_p_ff[2]) - CW'(s1_p_ff[3]);
      c_w[2]     = CW'(s1_p_ff[4]) - CW'(s1_p_ff[5]);
      s2_t_in[0] = TW'(s1_e_ff[0]) * TW'(c_w[0]);
      s2_t_in[1] = TW'(s1_e_ff[1]) * TW'(c_w[1]);
      s2_t_in[2] = TW'(s1_e_ff[2]) * TW'(c_w[2]);
   end

   always_comb begin
      det_w     = DW'(s2_t_ff[0]) - DW'(s2_t_ff[1]) + DW'(s2_t_ff[2]);
      s3_mag_in = det_w[DW-1] ? DW'(-det_w) : DW'(det_w);
   end

   always_comb begin
      sh_w      = {s3_mag_ff, {VOLUME_FRAC_BITS{1'b0}}} >> SCALE;
      s4_sat_in = |sh_w[XW-1:QW];
      biased_w  = {1'b0, sh_w[QW-1:0]} + (QW+1)'(tvu_pkg::ROUND_BIAS);
   end

   for (genvar j = 0; j < DS; j++) begin : g_div
      localparam int unsigned HI = QW - 1 - j * DB;
      logic [QW-1:0] w_src;
      logic [1:0]    r_src;
      logic [DB+1:0] res;
      if (j == 0) begin : g_first
         assign w_src = s4_m_ff;
         assign r_src = 2'd0;
      end else begin : g_next
         assign w_src = dw_ff[j-1];
         assign r_src = dr_ff[j-1];
      end
      assign res = div_chunk(r_src, w_src[HI -: DB]);
      always_comb begin
         dw_in[j]          = w_src;
         dw_in[j][HI -: DB] = res[DB-1:0];
         dr_in[j]          = res[DB+1:DB];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= (j == 0) ? s4_v_ff : dv_ff[(j == 0) ? 0 : j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dw_ff[j]   <= dw_in[j];
            dr_ff[j]   <= dr_in[j];
            ddg_ff[j]  <= (j == 0) ? s4_dg_ff  : ddg_ff[(j == 0) ? 0 : j-1];
            dsat_ff[j] <= (j == 0) ? s4_sat_ff : dsat_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   always_comb begin
      q_w = dw_ff[DS-1];
      if (ddg_ff[DS-1]) begin
         vol_in = '0;
      end else if (dsat_ff[DS-1] || (|q_w[QW-1:VW])) begin
         vol_in = '1;
      end else begin
         vol_in = q_w[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= head_valid;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         rsp_valid_ff <= dv_ff[DS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dg_ff          <= head_data[9*EW];
         s1_e_ff[0]        <= e_w[0];
         s1_e_ff[1]        <= e_w[1];
         s1_e_ff[2]        <= e_w[2];
         s1_p_ff           <= s1_p_in;
         s2_dg_ff          <= s1_dg_ff;
         s2_t_ff           <= s2_t_in;
         s3_dg_ff          <= s2_dg_ff;
         s3_mag_ff         <= s3_mag_in;
         s4_dg_ff          <= s3_dg_ff;
         s4_sat_ff         <= s4_sat_in;
         s4_m_ff           <= biased_w[QW:1];
         rsp_volume_ff     <= vol_in;
         rsp_degenerate_ff <= ddg_ff[DS-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_volume     = rsp_volume_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams tetrahedra through the volume unit and compares every volume and
// degenerate flag with a table value or an exact determinant prediction,
// under random idling on both channels and one long result hold-off
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   localparam int unsigned CF = 16;
   localparam int unsigned VF = 32;
   localparam int unsigned CW = CF + 1;
   localparam int unsigned ONE = 1 << CF;
   localparam int unsigned COORD_MAX = (1 << CW) - 1;
   localparam int unsigned RANDOM_ITEMS = 1830;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 40;

   typedef logic [CW-1:0] coord_type;
   typedef coord_type tetra_type [12];

   typedef struct {
      logic [tvu_pkg::VOLUME_W-1:0] volume;
      logic                         degenerate;
   } volume_type;

   // one directed row: vertices plus, where obvious, the expected volume
   typedef struct {
      tetra_type  verts;
      logic       known;
      volume_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_v [12];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [tvu_pkg::VOLUME_W-1:0] rsp_volume;
   logic rsp_degenerate;

   // idle percentages, changed by phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic hold_off = 1'b0;

   volume_type expected_volumes [$];
   int unsigned error_count = 0;
   int unsigned results_seen = 0;
   int unsigned degenerate_seen = 0;
   int unsigned saturated_seen = 0;
   longint unsigned cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < 12; i++) req_v[i] = '0;
   end

   tetrahedron_volume_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_vertex_a_x (req_v[0]),
      .req_vertex_a_y (req_v[1]),
      .req_vertex_a_z (req_v[2]),
      .req_vertex_b_x (req_v[3]),
      .req_vertex_b_y (req_v[4]),
      .req_vertex_b_z (req_v[5]),
      .req_vertex_c_x (req_v[6]),
      .req_vertex_c_y (req_v[7]),
      .req_vertex_c_z (req_v[8]),
      .req_vertex_d_x (req_v[9]),
      .req_vertex_d_y (req_v[10]),
      .req_vertex_d_z (req_v[11]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_volume     (rsp_volume),
      .rsp_degenerate (rsp_degenerate)
   );

   // exact volume: |det(b-a, c-a, d-a)| scaled to VF bits, divided by six,
   // halves rounded up, saturated to the field width
   function automatic volume_type predict_volume(input tetra_type t);
      volume_type r;
      logic signed [19:0] e [9];
      logic signed [63:0] c0, c1, c2;
      logic signed [127:0] det;
      logic [127:0] mag, scaled;
      int unsigned shift;
      for (int i = 0; i < 9; i++)
         e[i] = $signed({3'b000, t[3 + i]}) - $signed({3'b000, t[i % 3]});
      c0 = 64'(e[4]) * 64'(e[8]) - 64'(e[5]) * 64'(e[7]);
      c1 = 64'(e[3]) * 64'(e[8]) - 64'(e[5]) * 64'(e[6]);
      c2 = 64'(e[3]) * 64'(e[7]) - 64'(e[4]) * 64'(e[6]);
      det = 128'(e[0]) * 128'(c0) - 128'(e[1]) * 128'(c1) + 128'(e[2]) * 128'(c2);
      mag = det[127] ? 128'(-det) : 128'(det);
      shift = 3 * CF - VF;
      scaled = mag >> shift;
      r.degenerate = (t[9] == t[0] && t[10] == t[1] && t[11] == t[2]) ||
                     (t[9] == t[3] && t[10] == t[4] && t[11] == t[5]) ||
                     (t[9] == t[6] && t[10] == t[7] && t[11] == t[8]);
      if (scaled >= (128'd1 << tvu_pkg::QUOT_IN_BITS)) r.volume = '1;
      else begin
         scaled = (scaled + 3) / 6;
         r.volume = (scaled > 128'hFFFF_FFFF) ? '1 : scaled[31:0];
      end
      if (r.degenerate) r.volume = '0;
      return r;
   endfunction

   // drive one item at the falling edge and hold it until accepted
   task automatic send_tetra(input tetra_type t, input volume_type want, input logic known);
      volume_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      p = predict_volume(t);
      if (known && (p.volume !== want.volume || p.degenerate !== want.degenerate))
         $display("%0t note: table row disagrees with prediction", $time);
      for (int i = 0; i < 12; i++) req_v[i] <= t[i];
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_volumes.push_back(known ? want : p);
      @(negedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(9))
         0: return '0;
         1: return coord_type'(ONE);
         2: return coord_type'(COORD_MAX);
         3: return coord_type'($urandom_range(COORD_MAX));
         default: return coord_type'($urandom_range(ONE));
      endcase
   endfunction

   // random tetrahedron; some share a vertex or sit on a plane
   function automatic tetra_type rand_tetra();
      tetra_type t;
      int unsigned pick;
      for (int i = 0; i < 12; i++) t[i] = rand_coord();
      pick = $urandom_range(19);
      if (pick == 0) for (int i = 0; i < 3; i++) t[9 + i] = t[3 * $urandom_range(2) + i];
      else if (pick == 1) for (int i = 0; i < 3; i++) t[3 + i] = t[i];
      else if (pick == 2) for (int i = 0; i < 4; i++) t[3 * i + 2] = t[2];
      return t;
   endfunction

   function automatic row_type mk_row(input tetra_type t, input logic k,
                                      input logic [31:0] v, input logic d);
      row_type r;
      r.verts = t;
      r.known = k;
      r.want.volume = v;
      r.want.degenerate = d;
      return r;
   endfunction

   // receiver idling, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // result checking at the rising edge
   always @(posedge clock) begin
      volume_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_volumes.size() == 0) begin
            $display("%0t error: unexpected item volume=%h degenerate=%b",
                     $time, rsp_volume, rsp_degenerate);
            error_count++;
         end else begin
            w = expected_volumes.pop_front();
            if (rsp_volume !== w.volume) begin
               $display("%0t error: volume expected %h actual %h",
                        $time, w.volume, rsp_volume);
               error_count++;
            end
            if (rsp_degenerate !== w.degenerate) begin
               $display("%0t error: degenerate expected %b actual %b",
                        $time, w.degenerate, rsp_degenerate);
               error_count++;
            end
            if (w.degenerate) degenerate_seen++;
            if (w.volume == '1) saturated_seen++;
         end
      end
   end

   // run-length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d items outstanding", $time, expected_volumes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      tetra_type t;
      localparam coord_type O = coord_type'(ONE);
      localparam coord_type M = coord_type'(COORD_MAX);
      // unit corner tetrahedron: 1/6 of unit cube
      rows.push_back(mk_row('{0,0,0, O,0,0, 0,O,0, 0,0,O}, 1, 32'h2AAA_AAAB, 0));
      // all vertices at origin
      rows.push_back(mk_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, 32'h0, 1));
      // d equals b
      rows.push_back(mk_row('{0,0,0, O,O,O, 0,O,0, O,O,O}, 1, 32'h0, 1));
      // d equals c
      rows.push_back(mk_row('{0,0,0, O,0,0, 0,O,0, 0,O,0}, 1, 32'h0, 1));
      // a equals b, d apart: flat, not degenerate
      rows.push_back(mk_row('{0,0,0, 0,0,0, 0,O,0, 0,0,O}, 1, 32'h0, 0));
      // b equals c
      rows.push_back(mk_row('{O,O,O, 0,O,0, 0,O,0, 0,0,0}, 1, 32'h0, 0));
      // coordinates past one saturate the volume
      rows.push_back(mk_row('{0,0,0, M,0,0, 0,M,0, 0,0,M}, 1, 32'hFFFF_FFFF, 0));
      rows.push_back(mk_row('{M,M,M, 0,M,M, M,0,M, M,M,0}, 1, 32'hFFFF_FFFF, 0));
      // mirrored orientation, negative determinant
      rows.push_back(mk_row('{0,0,0, 0,O,0, O,0,0, 0,0,O}, 1, 32'h2AAA_AAAB, 0));
      // coplanar points
      rows.push_back(mk_row('{0,0,0, O,0,0, 0,O,0, O,O,0}, 1, 32'h0, 0));
      // smallest step tetrahedra, rounding near zero, then rows checked only against the prediction
      rows.push_back(mk_row('{0,0,0, 1,0,0, 0,1,0, 0,0,1}, 0, 0, 0));
      rows.push_back(mk_row('{M,M,M, M-1,M,M, M,M-1,M, M,M,M-1}, 0, 0, 0));
      rows.push_back(mk_row('{0,0,0, O,O,0, O,0,O, 0,O,O}, 0, 0, 0));
      rows.push_back(mk_row('{O,0,0, 0,O,0, 0,0,O, O,O,O}, 0, 0, 0));
      rows.push_back(mk_row('{17'h15555,17'h0AAAA,17'h1FFFF, 17'h0AAAA,17'h15555,0,
                              17'h1FFFF,0,17'h15555, 0,17'h1FFFF,17'h0AAAA}, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_tetra(rows[i].verts, rows[i].want, rows[i].known);

      // long result hold-off while items keep coming, so the input stalls
      fork
         begin
            hold_off = 1'b1;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 30; i++) begin
            t = rand_tetra();
            send_tetra(t, '{default: '0}, 0);
         end
      join

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 0) begin send_idle_pct = 23; recv_idle_pct = 87; end
         else if (i == RANDOM_ITEMS / 3) begin send_idle_pct = 87; recv_idle_pct = 23; end
         else if (i == 2 * RANDOM_ITEMS / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
         t = rand_tetra();
         send_tetra(t, '{default: '0}, 0);
      end
      req_valid <= 1'b0;

      while (expected_volumes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d volumes: %0d degenerate, %0d saturated, idle and hold-off mixes",
               results_seen, degenerate_seen, saturated_seen);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
